// ===== hdl/lct_pkg.sv =====
// Shared types, constants and the reset palette for the LRU color table.
`timescale 1ns / 1ps
`default_nettype none
package lct_pkg;

    localparam int SLOTS_DEF = 20;
    localparam int SLOT_W    = 5;
    localparam int COLOR_W   = 24;
    localparam int RANK_W    = 5;
    localparam int PALETTE_N = 20;
    localparam int TDATA_W   = 32;

    localparam logic OP_SELECT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // load input item, clear search state
        logic get_rank;  // select: fetch rank of named slot
        logic scan;      // lookup: one search step
        logic pick;      // lookup: resolve hit or replace victim
        logic promote;   // one rank update step
        logic out_load;  // load output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_lookup;
        logic in_range;
        logic last;
        logic out_busy;
    } t_sts;

    function automatic logic [COLOR_W-1:0] lct_palette(input logic [SLOT_W-1:0] idx);
        logic [COLOR_W-1:0] c;
        case (idx)
            5'd0:    c = 24'h000000;
            5'd1:    c = 24'h000080;
            5'd2:    c = 24'h008000;
            5'd3:    c = 24'h008080;
            5'd4:    c = 24'h800000;
            5'd5:    c = 24'h800080;
            5'd6:    c = 24'h808000;
            5'd7:    c = 24'hC0C0C0;
            5'd8:    c = 24'hC0DCC0;
            5'd9:    c = 24'hF0CAA6;
            5'd10:   c = 24'hF0FBFF;
            5'd11:   c = 24'hA4A0A0;
            5'd12:   c = 24'h808080;
            5'd13:   c = 24'h0000FF;
            5'd14:   c = 24'h00FF00;
            5'd15:   c = 24'h00FFFF;
            5'd16:   c = 24'hFF0000;
            5'd17:   c = 24'hFF00FF;
            5'd18:   c = 24'hFFFF00;
            5'd19:   c = 24'hFFFFFF;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/lct_ctrl.sv =====
// Sequencing state machine for the LRU color table.
`timescale 1ns / 1ps
`default_nettype none
module lct_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  lct_pkg::t_sts    i_sts,
    output lct_pkg::t_cmd    o_cmd
);
    import lct_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_PICK,
        S_PROMOTE,
        S_DONE
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.is_lookup) begin
                    n_state = S_SCAN;
                end else if (i_sts.in_range) begin
                    o_cmd.get_rank = 1'b1;
                    n_state        = S_PROMOTE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.last) n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_PROMOTE;
            end
            S_PROMOTE: begin
                o_cmd.promote = 1'b1;
                if (i_sts.last) n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/lct_datapath.sv =====
// Color and rank storage, sweep counter and result register.
`timescale 1ns / 1ps
`default_nettype none
module lct_datapath #(
    parameter int SLOTS = lct_pkg::SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  lct_pkg::t_cmd                     i_cmd,
    output lct_pkg::t_sts                     o_sts,
    input  wire logic [lct_pkg::TDATA_W-1:0]  i_s_tdata,
    input  wire logic [0:0]                   i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [lct_pkg::TDATA_W-1:0]       o_m_tdata,
    output logic [0:0]                        o_m_tuser
);
    import lct_pkg::*;

    localparam int CW = $clog2(SLOTS);

    logic [COLOR_W-1:0] r_colors [SLOTS];
    logic [RANK_W-1:0]  r_ranks  [SLOTS];

    logic               r_op;
    logic [SLOT_W-1:0]  r_idx;
    logic [COLOR_W-1:0] r_color;
    logic [CW-1:0]      r_cnt;
    logic               r_found;
    logic [CW-1:0]      r_match;
    logic [RANK_W-1:0]  r_match_rank;
    logic [RANK_W-1:0]  r_best;
    logic [CW-1:0]      r_victim;
    logic [CW-1:0]      r_slot;
    logic [RANK_W-1:0]  r_rank_sel;
    logic               r_hit;
    logic [COLOR_W-1:0] r_color_out;
    logic               r_out_valid;
    logic [SLOT_W-1:0]  r_out_slot;
    logic               r_out_hit;
    logic [COLOR_W-1:0] r_out_color;

    logic [CW-1:0]      w_rank_addr;
    logic [COLOR_W-1:0] w_color_rd;
    logic [RANK_W-1:0]  w_rank_rd;
    logic               w_in_range;
    logic               w_last;

    assign w_rank_addr = i_cmd.get_rank ? r_idx[CW-1:0] : r_cnt;
    assign w_color_rd  = r_colors[r_cnt];
    assign w_rank_rd   = r_ranks[w_rank_addr];
    assign w_in_range  = r_idx < SLOT_W'(SLOTS);
    assign w_last      = r_cnt == CW'(SLOTS - 1);

    assign o_sts.is_lookup = r_op == OP_LOOKUP;
    assign o_sts.in_range  = w_in_range;
    assign o_sts.last      = w_last;
    assign o_sts.out_busy  = r_out_valid && !i_m_tready;

    // Table state: reset loads the palette and the interleaved rank order
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_colors[i] <= (i < PALETTE_N) ? lct_palette(SLOT_W'(i)) : '0;
                r_ranks[i]  <= (i < (SLOTS + 1) / 2) ? RANK_W'(2 * i + 1)
                                                     : RANK_W'(2 * (SLOTS - i));
            end
        end else begin
            if (i_cmd.pick && !r_found) begin
                r_colors[r_victim] <= r_color;
            end
            if (i_cmd.promote) begin
                if (r_cnt == r_slot) begin
                    r_ranks[r_cnt] <= RANK_W'(1);
                end else if (w_rank_rd < r_rank_sel) begin
                    r_ranks[r_cnt] <= w_rank_rd + RANK_W'(1);
                end
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_s_tuser[0];
            r_idx    <= i_s_tdata[SLOT_W-1:0];
            r_color  <= i_s_tdata[SLOT_W +: COLOR_W];
            r_cnt    <= '0;
            r_found  <= 1'b0;
            r_best   <= '0;
            r_victim <= '0;
        end
        if (i_cmd.get_rank) begin
            r_slot     <= r_idx[CW-1:0];
            r_rank_sel <= w_rank_rd;
            r_hit      <= 1'b1;
            r_cnt      <= '0;
        end
        if (i_cmd.scan) begin
            // first match wins; victim is the lowest slot with the largest rank
            if (!r_found && w_color_rd == r_color) begin
                r_found      <= 1'b1;
                r_match      <= r_cnt;
                r_match_rank <= w_rank_rd;
            end
            if (w_rank_rd > r_best) begin
                r_best   <= w_rank_rd;
                r_victim <= r_cnt;
            end
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.pick) begin
            r_slot     <= r_found ? r_match : r_victim;
            r_rank_sel <= r_found ? r_match_rank : r_best;
            r_hit      <= r_found;
            r_cnt      <= '0;
        end
        if (i_cmd.promote) begin
            if (r_cnt == r_slot) r_color_out <= w_color_rd;
            r_cnt <= r_cnt + CW'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_op == OP_SELECT && !w_in_range) begin
                r_out_slot  <= r_idx;
                r_out_hit   <= 1'b0;
                r_out_color <= '0;
            end else begin
                r_out_slot  <= SLOT_W'(r_slot);
                r_out_hit   <= r_hit;
                r_out_color <= r_color_out;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(TDATA_W - SLOT_W - COLOR_W){1'b0}}, r_out_color, r_out_slot};
    assign o_m_tuser  = r_out_hit;

endmodule
`default_nettype wire

// ===== hdl/lru_color_table.sv =====
// LRU color table: controller plus storage datapath.
// Sequence: a select fetches the named slot's rank, then runs a rank sweep;
//   a lookup runs a search sweep, a pick step, then a rank sweep, one slot per cycle.
// Throughput: one item at a time; the next item is taken once the previous
//   result is loaded into the output register (it may still wait there).
// An out-of-range select skips the sweeps and returns a miss without touching state.
// Reset (synchronous, active low) loads the palette and interleaved ranks at once.
`timescale 1ns / 1ps
`default_nettype none
module lru_color_table #(
    parameter int SLOTS = lct_pkg::SLOTS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    // [4:0] slot_index, [28:5] color_value, [31:29] zero
    input  wire logic [lct_pkg::TDATA_W-1:0]  i_s_tdata,
    // [0] opcode
    input  wire logic [0:0]                   i_s_tuser,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    // [4:0] chosen_slot, [28:5] slot_color, [31:29] zero
    output logic [lct_pkg::TDATA_W-1:0]       o_m_tdata,
    // [0] hit
    output logic [0:0]                        o_m_tuser
);
    import lct_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    lct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lct_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input taken while an item is in flight");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwrote an untaken result");

    a_hit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[SLOT_W-1:0] < SLOT_W'(SLOTS)))
        else $error("hit reported on a slot outside the table");

    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.capture, w_cmd.get_rank, w_cmd.scan, w_cmd.pick,
                  w_cmd.promote, w_cmd.out_load}))
        else $error("conflicting datapath commands");

endmodule
`default_nettype wire
